// ===== design/khte_pkg.sv =====
`timescale 1ns / 1ps
package khte_pkg;
   localparam int NUM_BUCKETS      = 64;
   localparam int SLOTS_PER_BUCKET = 4;
   localparam int TOTAL_SLOTS      = NUM_BUCKETS * SLOTS_PER_BUCKET;
   localparam int SLOT_W           = $clog2(TOTAL_SLOTS);
   localparam int SUB_W            = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int BKT_W            = $clog2(NUM_BUCKETS + 1);
   localparam int KEY_W            = 16;
   localparam int ID_W             = 32;
   localparam int TAG_W            = 8;
   localparam int CNT_W            = 9;
   localparam int CFG_W            = 7;
   localparam int REC_W            = KEY_W + ID_W + TAG_W;
   localparam int SCNT_W           = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int REM_W            = KEY_W + 1;

   localparam logic [1:0] CMD_PUT    = 2'd0;
   localparam logic [1:0] CMD_ERASE  = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   localparam logic [0:0] REG_BUCKET_COUNT = 1'd0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVIDE,
      S_READ,
      S_SCAN,
      S_WRITE,
      S_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic rd_issue;
      logic scan_step;
      logic commit;
      logic rsp_load;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic scan_last;
   } stat_type;
endpackage

// ===== design/khte_if.sv =====
`timescale 1ns / 1ps
interface khte_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                cmd;
   logic [khte_pkg::KEY_W-1:0] key;
   logic [khte_pkg::ID_W-1:0]  entry_id;
   logic [khte_pkg::TAG_W-1:0] handler_tag;
   modport source (output valid, cmd, key, entry_id, handler_tag, input ready);
   modport sink (input valid, cmd, key, entry_id, handler_tag, output ready);
endinterface

interface khte_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic [khte_pkg::ID_W-1:0]  found_id;
   logic [khte_pkg::TAG_W-1:0] found_handler;
   logic [khte_pkg::CNT_W-1:0] entry_count;
   modport source (output valid, status, found_id, found_handler, entry_count, input ready);
   modport sink (input valid, status, found_id, found_handler, entry_count, output ready);
endinterface

// ===== design/khte_ram.sv =====
`timescale 1ns / 1ps
module khte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
   assign rdata = rdata_ff;
endmodule

// ===== design/khte_ctrl.sv =====
`timescale 1ns / 1ps
module khte_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  khte_pkg::stat_type   stat,
   output khte_pkg::ctrl_type   ctrl
);
   khte_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         khte_pkg::S_IDLE:    if (req_valid) state_in = khte_pkg::S_DIVIDE;
         khte_pkg::S_DIVIDE:  if (stat.div_done) state_in = khte_pkg::S_READ;
         khte_pkg::S_READ:    state_in = khte_pkg::S_SCAN;
         khte_pkg::S_SCAN:    if (stat.scan_last) state_in = khte_pkg::S_WRITE;
         khte_pkg::S_WRITE:   state_in = khte_pkg::S_RESPOND;
         khte_pkg::S_RESPOND: if (!rsp_valid_ff || rsp_ready) state_in = khte_pkg::S_IDLE;
         default:             state_in = khte_pkg::S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      ctrl = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         khte_pkg::S_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         khte_pkg::S_DIVIDE:  ctrl.div_step = 1'b1;
         khte_pkg::S_READ:    ctrl.rd_issue = 1'b1;
         khte_pkg::S_SCAN: begin
            ctrl.scan_step = 1'b1;
            ctrl.rd_issue = 1'b1;
         end
         khte_pkg::S_WRITE:   ctrl.commit = 1'b1;
         khte_pkg::S_RESPOND: ctrl.rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // The result register lets the next request enter while a result waits.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (ctrl.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= khte_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== design/khte_dp.sv =====
`timescale 1ns / 1ps
module khte_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  khte_pkg::ctrl_type               ctrl,
   output khte_pkg::stat_type               stat,
   input  logic [1:0]                       req_cmd,
   input  logic [khte_pkg::KEY_W-1:0]       req_key,
   input  logic [khte_pkg::ID_W-1:0]        req_entry_id,
   input  logic [khte_pkg::TAG_W-1:0]       req_handler_tag,
   input  logic [khte_pkg::CFG_W-1:0]       bucket_count,
   output logic [1:0]                       rsp_status,
   output logic [khte_pkg::ID_W-1:0]        rsp_found_id,
   output logic [khte_pkg::TAG_W-1:0]       rsp_found_handler,
   output logic [khte_pkg::CNT_W-1:0]       rsp_entry_count
);
   localparam int KW = khte_pkg::KEY_W;
   localparam int RW = khte_pkg::REM_W;

   logic [1:0]                     cmd_ff;
   logic [KW-1:0]                  key_ff;
   logic [khte_pkg::ID_W-1:0]      id_ff;
   logic [khte_pkg::TAG_W-1:0]     tag_ff;
   logic [khte_pkg::BKT_W-1:0]     mod_ff, mod_in;
   logic [RW-1:0]                  rem_ff, rem_in;
   logic [KW-1:0]                  quo_ff, quo_in;
   logic [$clog2(KW+1)-1:0]        dcnt_ff, dcnt_in;
   logic [khte_pkg::SCNT_W-1:0]    rcnt_ff;
   logic [khte_pkg::SCNT_W-1:0]    scnt_ff;
   logic                           hit_ff, free_ff;
   logic [khte_pkg::SUB_W-1:0]     hit_sub_ff, free_sub_ff;
   logic [khte_pkg::CNT_W-1:0]     held_ff;
   logic [khte_pkg::TOTAL_SLOTS-1:0] valid_ff;
   logic [1:0]                     status_code;
   logic [khte_pkg::ID_W-1:0]      rid_ff;
   logic [khte_pkg::TAG_W-1:0]     rtag_ff;

   logic [khte_pkg::SLOT_W-1:0]    base;
   logic [khte_pkg::SLOT_W-1:0]    raddr, waddr, cur_addr;
   logic [khte_pkg::REC_W-1:0]     rdata, wdata;
   logic                           we;
   logic [RW-1:0]                  trial;
   logic [khte_pkg::KEY_W-1:0]     rd_key;
   logic [khte_pkg::SUB_W-1:0]     cur_sub;

   // Effective modulus: zero reads as one, values above the bucket total saturate.
   always_comb begin
      if (bucket_count == '0) mod_in = khte_pkg::BKT_W'(1);
      else if (32'(bucket_count) > khte_pkg::NUM_BUCKETS)
         mod_in = khte_pkg::BKT_W'(khte_pkg::NUM_BUCKETS);
      else mod_in = khte_pkg::BKT_W'(bucket_count);
   end

   // Restoring division, one quotient bit a cycle; only the remainder is used.
   assign trial = {rem_ff[RW-2:0], quo_ff[KW-1]} - RW'(mod_ff);
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dcnt_in = dcnt_ff;
      if (ctrl.load) begin
         rem_in  = '0;
         quo_in  = req_key;
         dcnt_in = '0;
      end else if (ctrl.div_step) begin
         quo_in  = {quo_ff[KW-2:0], 1'b0};
         dcnt_in = dcnt_ff + 1'b1;
         if (!trial[RW-1]) rem_in = trial;
         else rem_in = {rem_ff[RW-2:0], quo_ff[KW-1]};
      end
   end
   assign stat.div_done = (32'(dcnt_ff) == KW - 1) && ctrl.div_step;

   assign base     = khte_pkg::SLOT_W'(rem_ff * khte_pkg::SLOTS_PER_BUCKET);
   assign raddr    = base + khte_pkg::SLOT_W'(rcnt_ff);
   assign cur_sub  = khte_pkg::SUB_W'(scnt_ff);
   assign cur_addr = base + khte_pkg::SLOT_W'(scnt_ff);
   assign rd_key   = rdata[khte_pkg::REC_W-1 -: KW];
   assign stat.scan_last = (32'(scnt_ff) == khte_pkg::SLOTS_PER_BUCKET - 1);

   // Write back on put hit or insert.
   always_comb begin
      we    = 1'b0;
      waddr = base + khte_pkg::SLOT_W'(hit_sub_ff);
      wdata = {key_ff, id_ff, tag_ff};
      if (ctrl.commit && cmd_ff == khte_pkg::CMD_PUT) begin
         if (hit_ff) we = 1'b1;
         else if (free_ff) begin
            we    = 1'b1;
            waddr = base + khte_pkg::SLOT_W'(free_sub_ff);
         end
      end
   end

   khte_ram #(.WIDTH(khte_pkg::REC_W), .DEPTH(khte_pkg::TOTAL_SLOTS)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Request capture, divider, slot scan.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      if (ctrl.load) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         id_ff  <= req_entry_id;
         tag_ff <= req_handler_tag;
         mod_ff <= mod_in;
      end
      if (ctrl.div_step) begin
         rcnt_ff <= '0;
         scnt_ff <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         hit_sub_ff <= '0;
         free_sub_ff <= '0;
      end else begin
         if (ctrl.rd_issue) rcnt_ff <= rcnt_ff + 1'b1;
         if (ctrl.scan_step) begin
            scnt_ff <= scnt_ff + 1'b1;
            if (valid_ff[cur_addr] && rd_key == key_ff && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_sub_ff <= cur_sub;
            end
            if (!valid_ff[cur_addr] && !free_ff) begin
               free_ff     <= 1'b1;
               free_sub_ff <= cur_sub;
            end
            if (valid_ff[cur_addr] && rd_key == key_ff && !hit_ff) begin
               rid_ff  <= rdata[khte_pkg::REC_W-KW-1 -: khte_pkg::ID_W];
               rtag_ff <= rdata[khte_pkg::TAG_W-1:0];
            end
         end
      end
   end

   // Valid bits, count and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         held_ff  <= '0;
      end else if (ctrl.commit) begin
         if (cmd_ff == khte_pkg::CMD_PUT && !hit_ff && free_ff) begin
            valid_ff[base + khte_pkg::SLOT_W'(free_sub_ff)] <= 1'b1;
            held_ff <= held_ff + 1'b1;
         end else if (cmd_ff == khte_pkg::CMD_ERASE && hit_ff) begin
            valid_ff[base + khte_pkg::SLOT_W'(hit_sub_ff)] <= 1'b0;
            held_ff <= held_ff - 1'b1;
         end
      end
   end

   always_comb begin
      status_code = khte_pkg::ST_OK;
      case (cmd_ff) inside
         khte_pkg::CMD_PUT:    if (!hit_ff && !free_ff) status_code = khte_pkg::ST_FULL;
         khte_pkg::CMD_ERASE, khte_pkg::CMD_LOOKUP:
            if (!hit_ff) status_code = khte_pkg::ST_MISSING;
         default: status_code = khte_pkg::ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_status      <= status_code;
         rsp_entry_count <= held_ff;
         if (cmd_ff == khte_pkg::CMD_LOOKUP && hit_ff) begin
            rsp_found_id      <= rid_ff;
            rsp_found_handler <= rtag_ff;
         end else begin
            rsp_found_id      <= '0;
            rsp_found_handler <= '0;
         end
      end
   end
endmodule

// ===== design/keyed_hash_table_engine.sv =====
`timescale 1ns / 1ps
// Keyed hash table engine: a map from 16-bit keys to a 32-bit id and 8-bit
// handler tag, held in 64 buckets of 4 slots in one record RAM with one read
// and one write port. The bucket is the key modulo the bucket_count register
// (zero reads as one, values above 64 saturate). Each request passes through
// the bit-serial remainder unit, then one RAM read per slot of the bucket, a
// write-back step and a result step. Slot valid bits are flip-flops cleared
// by reset, so the table is empty at once after reset with no clearing pass.
// One result per request; the result register lets the next request enter.
module keyed_hash_table_engine (
   input  logic        clock,
   input  logic        reset,
   khte_req_if.sink    req,
   khte_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   khte_pkg::ctrl_type ctrl;
   khte_pkg::stat_type stat;
   logic [khte_pkg::CFG_W-1:0] bucket_count_ff;

   // Configuration register.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= khte_pkg::CFG_W'(64);
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == khte_pkg::REG_BUCKET_COUNT) begin
         bucket_count_ff <= csr_pwdata[khte_pkg::CFG_W-1:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == khte_pkg::REG_BUCKET_COUNT)
                       ? {25'd0, bucket_count_ff} : 32'd0;

   khte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   khte_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_cmd           (req.cmd),
      .req_key           (req.key),
      .req_entry_id      (req.entry_id),
      .req_handler_tag   (req.handler_tag),
      .bucket_count      (bucket_count_ff),
      .rsp_status        (rsp.status),
      .rsp_found_id      (rsp.found_id),
      .rsp_found_handler (rsp.found_handler),
      .rsp_entry_count   (rsp.entry_count)
   );
endmodule
